>>> rtl/z80ed_pkg.sv
// Shared definitions for the Z80 ED-group ALU: operation codes, flag bit positions
// and small helper functions. No dependencies; imported by the core and its checker.
package z80ed_pkg;

  // Operation codes carried in the kind field.
  typedef enum logic [4:0] {
    KIND_ADC_HL = 5'd0,
    KIND_SBC_HL = 5'd1,
    KIND_NEG    = 5'd2,
    KIND_RRD    = 5'd3,
    KIND_RLD    = 5'd4,
    KIND_LD_A_R = 5'd5,
    KIND_LDI    = 5'd6,
    KIND_LDD    = 5'd7,
    KIND_LDIR   = 5'd8,
    KIND_LDDR   = 5'd9,
    KIND_CPI    = 5'd10,
    KIND_CPD    = 5'd11,
    KIND_CPIR   = 5'd12,
    KIND_CPDR   = 5'd13,
    KIND_OUTI   = 5'd14,
    KIND_OUTD   = 5'd15,
    KIND_OTIR   = 5'd16
  } kind_t;

  // Bit positions inside the flag register F.
  localparam int unsigned FLAG_S  = 7;
  localparam int unsigned FLAG_Z  = 6;
  localparam int unsigned FLAG_F5 = 5;
  localparam int unsigned FLAG_H  = 4;
  localparam int unsigned FLAG_F3 = 3;
  localparam int unsigned FLAG_P  = 2;
  localparam int unsigned FLAG_N  = 1;
  localparam int unsigned FLAG_C  = 0;

  // Even parity of a byte: 1 when the number of set bits is even.
  function automatic logic even_parity(input logic [7:0] v);
    return ~^v;
  endfunction

endpackage

>>> rtl/z80_ed_group_alu_core.sv
// Z80 ED-group register and flag datapath with registered input and result stages.
// Each operation is held first in the input register and then in the result register.
// Throughput: one operation per cycle; a stalled result blocks the input only once the
// input register also holds an operation, so two transfers can be outstanding.
// Reset (synchronous, active high) clears both valid bits; payload registers are not reset.
// Depends on z80ed_pkg.
module z80_ed_group_alu_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  kind,
  input  logic [7:0]  acc,
  input  logic [7:0]  flags_in,
  input  logic [15:0] pair_operand,
  input  logic [15:0] hl_in,
  input  logic [15:0] bc_in,
  input  logic [15:0] de_in,
  input  logic [7:0]  mem_byte,
  input  logic [7:0]  refresh_reg,
  input  logic        iff2,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  acc_out,
  output logic [7:0]  flags_out,
  output logic [15:0] hl_out,
  output logic [15:0] bc_out,
  output logic [15:0] de_out,
  output logic        mem_write,
  output logic [15:0] mem_write_addr,
  output logic [7:0]  mem_write_data,
  output logic        port_write,
  output logic [7:0]  port_data,
  output logic        repeat_res
);
  import z80ed_pkg::*;

  // Input register stage.
  logic        s1_valid;
  logic [4:0]  s1_kind;
  logic [7:0]  s1_acc;
  logic [7:0]  s1_flags;
  logic [15:0] s1_op;
  logic [15:0] s1_hl;
  logic [15:0] s1_bc;
  logic [15:0] s1_de;
  logic [7:0]  s1_mem;
  logic [7:0]  s1_r;
  logic        s1_iff2;

  // Next result values from the datapath.
  logic [7:0]  acc_next;
  logic [7:0]  flags_next;
  logic [15:0] hl_next;
  logic [15:0] bc_next;
  logic [15:0] de_next;
  logic        mem_write_next;
  logic [15:0] mem_write_addr_next;
  logic [7:0]  mem_write_data_next;
  logic        port_write_next;
  logic [7:0]  port_data_next;
  logic        repeat_next;

  logic s1_advance;

  // The result register can take a new value when empty or when its transfer completes.
  assign s1_advance = !out_valid || out_ready;
  assign in_ready   = !s1_valid || s1_advance;

  // Input stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // Input stage payload.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind  <= kind;
      s1_acc   <= acc;
      s1_flags <= flags_in;
      s1_op    <= pair_operand;
      s1_hl    <= hl_in;
      s1_bc    <= bc_in;
      s1_de    <= de_in;
      s1_mem   <= mem_byte;
      s1_r     <= refresh_reg;
      s1_iff2  <= iff2;
    end
  end

  // Operation datapath.
  always_comb begin
    logic        cin;
    logic [16:0] sum17;
    logic [12:0] sum13;
    logic [16:0] dif17;
    logic [12:0] dif13;
    logic [15:0] res16;
    logic [7:0]  res8;
    logic [7:0]  ld_sum;
    logic [7:0]  cp_dif;
    logic        cp_half;
    logic [7:0]  cp_adj;
    logic [15:0] hl_step;
    logic [15:0] de_step;
    logic [15:0] bc_dec;
    logic [7:0]  b_dec;
    logic [8:0]  out_sum;

    cin     = s1_flags[FLAG_C];
    sum17   = {1'b0, s1_hl} + {1'b0, s1_op} + {16'd0, cin};
    sum13   = {1'b0, s1_hl[11:0]} + {1'b0, s1_op[11:0]} + {12'd0, cin};
    dif17   = {1'b0, s1_hl} - {1'b0, s1_op} - {16'd0, cin};
    dif13   = {1'b0, s1_hl[11:0]} - {1'b0, s1_op[11:0]} - {12'd0, cin};
    res16   = 16'd0;
    res8    = 8'd0;
    ld_sum  = s1_mem + s1_acc;
    cp_dif  = s1_acc - s1_mem;
    cp_half = s1_acc[3:0] < s1_mem[3:0];
    cp_adj  = cp_dif - {7'd0, cp_half};
    bc_dec  = s1_bc - 16'd1;
    b_dec   = s1_bc[15:8] - 8'd1;
    hl_step = s1_hl + 16'd1;
    de_step = s1_de + 16'd1;
    out_sum = 9'd0;

    // Pass-through defaults, as for unused codes.
    acc_next            = s1_acc;
    flags_next          = s1_flags;
    hl_next             = s1_hl;
    bc_next             = s1_bc;
    de_next             = s1_de;
    mem_write_next      = 1'b0;
    mem_write_addr_next = 16'd0;
    mem_write_data_next = 8'd0;
    port_write_next     = 1'b0;
    port_data_next      = 8'd0;
    repeat_next         = 1'b0;

    unique case (kind_t'(s1_kind))
      KIND_ADC_HL: begin
        res16                = sum17[15:0];
        hl_next              = res16;
        flags_next           = 8'd0;
        flags_next[FLAG_S]   = res16[15];
        flags_next[FLAG_Z]   = (res16 == 16'd0);
        flags_next[FLAG_F5]  = res16[13];
        flags_next[FLAG_H]   = sum13[12];
        flags_next[FLAG_F3]  = res16[11];
        flags_next[FLAG_P]   = !(s1_hl[15] ^ s1_op[15]) && (s1_hl[15] ^ res16[15]);
        flags_next[FLAG_C]   = sum17[16];
      end
      KIND_SBC_HL: begin
        res16                = dif17[15:0];
        hl_next              = res16;
        flags_next           = 8'd0;
        flags_next[FLAG_S]   = res16[15];
        flags_next[FLAG_Z]   = (res16 == 16'd0);
        flags_next[FLAG_F5]  = res16[13];
        flags_next[FLAG_H]   = dif13[12];
        flags_next[FLAG_F3]  = res16[11];
        flags_next[FLAG_P]   = (s1_hl[15] ^ s1_op[15]) && (s1_hl[15] ^ res16[15]);
        flags_next[FLAG_N]   = 1'b1;
        flags_next[FLAG_C]   = dif17[16];
      end
      KIND_NEG: begin
        res8                 = 8'd0 - s1_acc;
        acc_next             = res8;
        flags_next           = 8'd0;
        flags_next[FLAG_S]   = res8[7];
        flags_next[FLAG_Z]   = (res8 == 8'd0);
        flags_next[FLAG_F5]  = res8[5];
        flags_next[FLAG_H]   = (s1_acc[3:0] != 4'd0);
        flags_next[FLAG_F3]  = res8[3];
        flags_next[FLAG_P]   = (s1_acc == 8'h80);
        flags_next[FLAG_N]   = 1'b1;
        flags_next[FLAG_C]   = (s1_acc != 8'd0);
      end
      KIND_RRD, KIND_RLD: begin
        if (s1_kind == KIND_RRD) begin
          res8                = {s1_acc[7:4], s1_mem[3:0]};
          mem_write_data_next = {s1_acc[3:0], s1_mem[7:4]};
        end else begin
          res8                = {s1_acc[7:4], s1_mem[7:4]};
          mem_write_data_next = {s1_mem[3:0], s1_acc[3:0]};
        end
        acc_next             = res8;
        mem_write_next       = 1'b1;
        mem_write_addr_next  = s1_hl;
        flags_next           = 8'd0;
        flags_next[FLAG_S]   = res8[7];
        flags_next[FLAG_Z]   = (res8 == 8'd0);
        flags_next[FLAG_F5]  = res8[5];
        flags_next[FLAG_F3]  = res8[3];
        flags_next[FLAG_P]   = even_parity(res8);
        flags_next[FLAG_C]   = cin;
      end
      KIND_LD_A_R: begin
        acc_next             = s1_r;
        flags_next           = 8'd0;
        flags_next[FLAG_S]   = s1_r[7];
        flags_next[FLAG_Z]   = (s1_r == 8'd0);
        flags_next[FLAG_F5]  = s1_r[5];
        flags_next[FLAG_F3]  = s1_r[3];
        flags_next[FLAG_P]   = s1_iff2;
        flags_next[FLAG_C]   = cin;
      end
      KIND_LDI, KIND_LDD, KIND_LDIR, KIND_LDDR: begin
        // Increment for LDI/LDIR, decrement for LDD/LDDR.
        if (s1_kind == KIND_LDI || s1_kind == KIND_LDIR) begin
          hl_next = hl_step;
          de_next = de_step;
        end else begin
          hl_next = s1_hl - 16'd1;
          de_next = s1_de - 16'd1;
        end
        bc_next              = bc_dec;
        mem_write_next       = 1'b1;
        mem_write_addr_next  = s1_de;
        mem_write_data_next  = s1_mem;
        flags_next           = 8'd0;
        flags_next[FLAG_S]   = s1_flags[FLAG_S];
        flags_next[FLAG_Z]   = s1_flags[FLAG_Z];
        flags_next[FLAG_F5]  = ld_sum[1];
        flags_next[FLAG_F3]  = ld_sum[3];
        flags_next[FLAG_P]   = (bc_dec != 16'd0);
        flags_next[FLAG_C]   = s1_flags[FLAG_C];
        repeat_next          = (s1_kind == KIND_LDIR || s1_kind == KIND_LDDR)
                               && (bc_dec != 16'd0);
      end
      KIND_CPI, KIND_CPD, KIND_CPIR, KIND_CPDR: begin
        if (s1_kind == KIND_CPI || s1_kind == KIND_CPIR) begin
          hl_next = hl_step;
        end else begin
          hl_next = s1_hl - 16'd1;
        end
        bc_next              = bc_dec;
        flags_next           = 8'd0;
        flags_next[FLAG_S]   = cp_dif[7];
        flags_next[FLAG_Z]   = (cp_dif == 8'd0);
        flags_next[FLAG_F5]  = cp_adj[1];
        flags_next[FLAG_H]   = cp_half;
        flags_next[FLAG_F3]  = cp_adj[3];
        flags_next[FLAG_P]   = (bc_dec != 16'd0);
        flags_next[FLAG_N]   = 1'b1;
        flags_next[FLAG_C]   = cin;
        repeat_next          = (s1_kind == KIND_CPIR || s1_kind == KIND_CPDR)
                               && (bc_dec != 16'd0) && (cp_dif != 8'd0);
      end
      KIND_OUTI, KIND_OUTD, KIND_OTIR: begin
        if (s1_kind == KIND_OUTD) begin
          hl_next = s1_hl - 16'd1;
        end else begin
          hl_next = hl_step;
        end
        bc_next              = {b_dec, s1_bc[7:0]};
        port_write_next      = 1'b1;
        port_data_next       = s1_mem;
        // Carry out of the byte plus the new L sets both H and C.
        out_sum              = {1'b0, s1_mem} + {1'b0, hl_next[7:0]};
        flags_next           = 8'd0;
        flags_next[FLAG_S]   = b_dec[7];
        flags_next[FLAG_Z]   = (b_dec == 8'd0);
        flags_next[FLAG_F5]  = b_dec[5];
        flags_next[FLAG_H]   = out_sum[8];
        flags_next[FLAG_F3]  = b_dec[3];
        flags_next[FLAG_P]   = even_parity({5'd0, out_sum[2:0]} ^ b_dec);
        flags_next[FLAG_N]   = s1_mem[7];
        flags_next[FLAG_C]   = out_sum[8];
        repeat_next          = (s1_kind == KIND_OTIR) && (b_dec != 8'd0);
      end
      default: begin
        acc_next = s1_acc;
      end
    endcase
  end

  // Result register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (s1_valid && s1_advance) begin
      acc_out        <= acc_next;
      flags_out      <= flags_next;
      hl_out         <= hl_next;
      bc_out         <= bc_next;
      de_out         <= de_next;
      mem_write      <= mem_write_next;
      mem_write_addr <= mem_write_addr_next;
      mem_write_data <= mem_write_data_next;
      port_write     <= port_write_next;
      port_data      <= port_data_next;
      repeat_res     <= repeat_next;
    end
  end

endmodule

>>> rtl/z80ed_checker.sv
// Port-level checker for the Z80 ED-group ALU core, attached by a bind statement.
// Depends on z80ed_pkg and on the port list of z80_ed_group_alu_core.
module z80ed_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  flags_out,
  input logic [15:0] hl_out,
  input logic        mem_write,
  input logic [15:0] mem_write_addr,
  input logic [7:0]  mem_write_data,
  input logic        port_write,
  input logic [7:0]  port_data,
  input logic        repeat_res
);
  import z80ed_pkg::*;

  // A stalled result stays valid and keeps its HL and flag values until its transfer.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hl_out) && $stable(flags_out))
    else $error("stalled result changed");

  // No result is shown in the cycle after reset.
  assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // A result never asks for both a memory write and a port write, and idle requests are zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(mem_write && port_write)
      && (mem_write || (mem_write_addr == 16'd0 && mem_write_data == 8'd0))
      && (port_write || port_data == 8'd0))
    else $error("inconsistent write requests");

  // Only block loads, compares and outputs repeat; loads and compares then show P/V set.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && repeat_res |-> port_write
      || ((mem_write || flags_out[FLAG_N]) && flags_out[FLAG_P]))
    else $error("repeat without a block operation");

endmodule

bind z80_ed_group_alu_core z80ed_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .flags_out      (flags_out),
  .hl_out         (hl_out),
  .mem_write      (mem_write),
  .mem_write_addr (mem_write_addr),
  .mem_write_data (mem_write_data),
  .port_write     (port_write),
  .port_data      (port_data),
  .repeat_res     (repeat_res)
);
